// ----- sv/rect_add_rect_sum_fenwick_mod_macros.svh -----
// Assertion macros for the rectangle add / sum engine.
`ifndef RECT_ADD_RECT_SUM_FENWICK_MOD_MACROS_SVH
`define RECT_ADD_RECT_SUM_FENWICK_MOD_MACROS_SVH
`ifndef SYNTHESIS
`define RAS_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define RAS_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define RAS_ASSERT_IMP(label, clk, rst, a, c)
`define RAS_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ----- sv/ras_pkg.sv -----
`default_nettype none
package ras_pkg;
   localparam int TREE_SIZE_DEF    = 4096;
   localparam int ANSWER_SLOTS_DEF = 1024;
   localparam logic [29:0] MODP    = 30'd1000000007;

   typedef struct packed {
      logic        operation;
      logic [30:0] x_coord;
      logic [30:0] y_coord;
      logic [12:0] y_index;
      logic signed [31:0] weight;
      logic [9:0]  query_id;
      logic        sign_negative;
   } req_type;

   typedef struct packed {
      logic [9:0]  answer_id;
      logic [29:0] answer_value;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_PREP, ST_MUL, ST_UPD_RD, ST_UPD_WR,
      ST_QRY_RD, ST_QRY_ACC, ST_COMB, ST_ANS_RD, ST_ANS_WR, ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;
      logic load;
      logic prep;
      logic mul_step;
      logic tree_rd;
      logic tree_wr;
      logic qry_acc;
      logic comb_step;
      logic ans_rd;
      logic ans_wr;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_done;
      logic is_query;
      logic walk_done;
      logic mul_done;
      logic comb_done;
   } status_type;

   function automatic logic [29:0] add_mod(input logic [29:0] a, input logic [29:0] b);
      logic [30:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, MODP}) s = s - {1'b0, MODP};
      return s[29:0];
   endfunction

   function automatic logic [29:0] sub_mod(input logic [29:0] a, input logic [29:0] b);
      logic [30:0] s;
      s = {1'b0, a} + {1'b0, MODP} - {1'b0, b};
      if (s >= {1'b0, MODP}) s = s - {1'b0, MODP};
      return s[29:0];
   endfunction

   // reduce a value below 3*P (31 bits)
   function automatic logic [29:0] red31(input logic [31:0] a);
      logic [31:0] s;
      s = a;
      if (s >= {2'b0, MODP}) s = s - {2'b0, MODP};
      if (s >= {2'b0, MODP}) s = s - {2'b0, MODP};
      return s[29:0];
   endfunction
endpackage
`default_nettype wire

// ----- sv/ras_mulmod.sv -----
`default_nettype none
// Serial modular multiplier: two bits of b per cycle; busy after start until all 30 bits of b are done.
module ras_mulmod import ras_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [29:0] a,
   input  wire logic [29:0] b,
   output logic             done,
   output logic [29:0]      prod
);
   logic [29:0] acc_ff, acc_in, b_ff, b_in, a_ff, a_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [29:0] t, a2, a3;

   always_comb begin
      acc_in = acc_ff; b_in = b_ff; a_in = a_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      t = add_mod(acc_ff, acc_ff);
      t = add_mod(t, t);
      a2 = add_mod(a_ff, a_ff);
      a3 = add_mod(a2, a_ff);
      if (start) begin
         acc_in = '0; b_in = b; a_in = a; cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         case (b_ff[29:28])
            2'd1:    acc_in = add_mod(t, a_ff);
            2'd2:    acc_in = add_mod(t, a2);
            2'd3:    acc_in = add_mod(t, a3);
            default: acc_in = t;
         endcase
         b_in = {b_ff[27:0], 2'b00};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd14) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; b_ff <= b_in; a_ff <= a_in; cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   // a start in the same cycle as done captures prod and begins the next product
   assign done = !busy_ff;
   assign prod = acc_ff;
endmodule
`default_nettype wire

// ----- sv/ras_datapath.sv -----
`default_nettype none
`include "rect_add_rect_sum_fenwick_mod_macros.svh"
module ras_datapath import ras_pkg::*; #(
   parameter int TREE_SIZE    = TREE_SIZE_DEF,
   parameter int ANSWER_SLOTS = ANSWER_SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       status,
   input  wire req_type     req,
   input  wire logic [12:0] index_count,
   output rsp_type          rsp
);
   localparam int IW = $clog2(TREE_SIZE + 1);
   localparam int AW = (ANSWER_SLOTS > 1) ? $clog2(ANSWER_SLOTS) : 1;
   localparam int CW = (IW > AW) ? IW : AW;
   // reciprocal for the slot remainder of a 10-bit query id
   localparam int SLOT_RECIP = (ANSWER_SLOTS >= 1024) ? 1
                               : ((1 << 20) + ANSWER_SLOTS - 1) / ANSWER_SLOTS;

   logic [119:0] tree_mem [TREE_SIZE + 1];
   logic [29:0]  ans_mem [ANSWER_SLOTS];
   logic [119:0] tree_rd_ff;
   logic [29:0]  ans_rd_ff;

   logic [CW:0]  clr_ff;
   logic [16:0]  pos_ff;
   logic [16:0]  bnd;
   logic [29:0]  x_ff, y_ff, w_ff;
   logic [AW-1:0] slot_ff;
   logic         op_ff, neg_ff;
   logic [29:0]  d0_ff, d1_ff, d2_ff, d3_ff;
   logic [29:0]  s0_ff, s1_ff, s2_ff, s3_ff;
   logic [29:0]  v_ff;
   logic [2:0]   mst_ff;
   logic [29:0]  ma, mb;
   logic         mstart, mdone;
   logic [29:0]  mprod;
   logic [29:0]  xp, yp, res_value;
   logic [IW-1:0] addr;
   logic [30:0]  qid_scaled;
   logic [9:0]   qid_quot, qid_rem;

   assign bnd = (17'(index_count) > 17'(TREE_SIZE)) ? 17'(TREE_SIZE) : 17'(index_count);
   assign addr = pos_ff[IW-1:0];
   assign xp = add_mod(x_ff, 30'd1);
   assign yp = add_mod(y_ff, 30'd1);

   assign qid_scaled = 31'(req.query_id) * 31'(SLOT_RECIP);
   assign qid_quot   = qid_scaled[29:20];
   assign qid_rem    = (ANSWER_SLOTS >= 1024) ? req.query_id
                       : req.query_id - qid_quot * 10'(ANSWER_SLOTS);

   // each step starts the next product; the finished one is still on mprod
   always_comb begin
      ma = w_ff; mb = y_ff;
      if (cmd.prep) begin
         ma = op_ff ? xp : w_ff;
         mb = op_ff ? yp : y_ff;
      end else begin
         unique case (mst_ff)
            3'd0: begin ma = w_ff;  mb = x_ff;  end
            3'd1: begin ma = mprod; mb = y_ff;  end
            3'd3: begin ma = mprod; mb = s0_ff; end
            3'd4: begin ma = xp;    mb = s1_ff; end
            3'd5: begin ma = yp;    mb = s2_ff; end
            default: begin ma = w_ff; mb = y_ff; end
         endcase
      end
   end
   assign mstart = cmd.prep || cmd.mul_step || cmd.comb_step;

   ras_mulmod u_mul (
      .clock(clock), .reset(reset), .start(mstart), .a(ma), .b(mb),
      .done(mdone), .prod(mprod)
   );

   logic [31:0] wmag;
   assign wmag = 32'd0 - req.weight;

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
      if (cmd.clear_step) begin
         if (clr_ff <= (CW+1)'(TREE_SIZE)) tree_mem[clr_ff[IW-1:0]] <= '0;
         if (clr_ff < (CW+1)'(ANSWER_SLOTS)) ans_mem[clr_ff[AW-1:0]] <= '0;
      end
      if (cmd.load) begin
         op_ff  <= req.operation;
         x_ff   <= red31({1'b0, req.x_coord});
         y_ff   <= red31({1'b0, req.y_coord});
         if (req.weight[31]) w_ff <= sub_mod(30'd0, red31(wmag));
         else w_ff <= red31(req.weight);
         slot_ff <= AW'(qid_rem);
         neg_ff <= req.sign_negative;
         pos_ff <= {4'b0, req.y_index};
         mst_ff <= 3'd0;
         s0_ff <= '0; s1_ff <= '0; s2_ff <= '0; s3_ff <= '0;
      end
      if (cmd.prep) begin
         if (op_ff) begin
            if (pos_ff > bnd) pos_ff <= bnd;
            mst_ff <= 3'd3;
         end else begin
            mst_ff <= 3'd0;
         end
         d0_ff <= w_ff;
      end
      if (cmd.mul_step) begin
         unique case (mst_ff)
            3'd0: d1_ff <= mprod;
            3'd1: d2_ff <= mprod;
            default: d3_ff <= mprod;
         endcase
         mst_ff <= mst_ff + 3'd1;
      end
      if (cmd.tree_rd) tree_rd_ff <= tree_mem[addr];
      if (cmd.tree_wr) begin
         tree_mem[addr] <= {add_mod(tree_rd_ff[119:90], d0_ff),
                            add_mod(tree_rd_ff[89:60], d1_ff),
                            add_mod(tree_rd_ff[59:30], d2_ff),
                            add_mod(tree_rd_ff[29:0], d3_ff)};
         pos_ff <= pos_ff + (pos_ff & (17'd0 - pos_ff));
      end
      if (cmd.qry_acc) begin
         s0_ff <= add_mod(s0_ff, tree_rd_ff[119:90]);
         s1_ff <= add_mod(s1_ff, tree_rd_ff[89:60]);
         s2_ff <= add_mod(s2_ff, tree_rd_ff[59:30]);
         s3_ff <= add_mod(s3_ff, tree_rd_ff[29:0]);
         pos_ff <= pos_ff - (pos_ff & (17'd0 - pos_ff));
      end
      if (cmd.comb_step) begin
         unique case (mst_ff)
            3'd4:       v_ff <= mprod;
            3'd5, 3'd6: v_ff <= sub_mod(v_ff, mprod);
            default:    v_ff <= v_ff;
         endcase
         mst_ff <= mst_ff + 3'd1;
      end
      if (cmd.ans_rd) ans_rd_ff <= ans_mem[slot_ff];
      if (cmd.ans_wr) begin
         ans_mem[slot_ff] <= res_value;
      end
   end

   // final value including S3 term
   logic [29:0] vq;
   assign vq = add_mod(v_ff, s3_ff);
   always_comb res_value = neg_ff ? sub_mod(ans_rd_ff, vq) : add_mod(ans_rd_ff, vq);

   always_ff @(posedge clock) begin
      if (cmd.ans_wr) begin
         rsp.answer_id    <= 10'(slot_ff);
         rsp.answer_value <= res_value;
      end
   end

   assign status.clear_done = (clr_ff > (CW+1)'(TREE_SIZE))
                              && (clr_ff >= (CW+1)'(ANSWER_SLOTS));
   assign status.is_query   = op_ff;
   assign status.walk_done  = op_ff ? (pos_ff == 17'd0) : (pos_ff == 17'd0 || pos_ff > bnd);
   assign status.mul_done   = mdone;
   assign status.comb_done  = (mst_ff == 3'd7);

   `RAS_ASSERT_IMP(a_wr_in_range, clock, reset, cmd.tree_wr, pos_ff != 17'd0 && pos_ff <= bnd)
   `RAS_ASSERT_IMP(a_rd_wr_excl, clock, reset, cmd.tree_wr, !cmd.tree_rd)
   `RAS_ASSERT_NEXT(a_slot_stable, clock, reset, cmd.ans_rd, $stable(slot_ff))
endmodule
`default_nettype wire

// ----- sv/ras_ctrl.sv -----
`default_nettype none
`include "rect_add_rect_sum_fenwick_mod_macros.svh"
module ras_ctrl import ras_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire status_type status,
   output cmd_type         cmd,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready
);
   state_type state_ff, state_in;
   logic rv_ff, rv_in;
   logic [1:0] mul_cnt_ff, mul_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rv_in = rv_ff;
      req_ready = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = status.is_query ? ST_QRY_RD : ST_MUL;
         end
         ST_MUL: begin
            // three products: stop after the third
            if (status.mul_done) begin
               cmd.mul_step = 1'b1;
               if (mul_cnt_ff == 2'd2) state_in = ST_UPD_RD;
            end
         end
         ST_UPD_RD: begin
            if (status.walk_done) state_in = ST_IDLE;
            else begin
               cmd.tree_rd = 1'b1;
               state_in = ST_UPD_WR;
            end
         end
         ST_UPD_WR: begin
            cmd.tree_wr = 1'b1;
            state_in = ST_UPD_RD;
         end
         ST_QRY_RD: begin
            if (status.walk_done) state_in = ST_COMB;
            else begin
               cmd.tree_rd = 1'b1;
               state_in = ST_QRY_ACC;
            end
         end
         ST_QRY_ACC: begin
            cmd.qry_acc = 1'b1;
            state_in = ST_QRY_RD;
         end
         ST_COMB: begin
            if (status.comb_done) state_in = ST_ANS_RD;
            else if (status.mul_done) cmd.comb_step = 1'b1;
         end
         ST_ANS_RD: begin
            cmd.ans_rd = 1'b1;
            state_in = ST_ANS_WR;
         end
         ST_ANS_WR: begin
            if (!rv_ff || rsp_ready) begin
               cmd.ans_wr = 1'b1;
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_cnt_in = mul_cnt_ff;
      if (cmd.prep) mul_cnt_in = '0;
      else if (cmd.mul_step) mul_cnt_in = mul_cnt_ff + 2'd1;
   end
   always_ff @(posedge clock) begin
      if (reset) mul_cnt_ff <= '0;
      else mul_cnt_ff <= mul_cnt_in;
   end

   assign rsp_valid = rv_ff;

   `RAS_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE)
   `RAS_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.ans_wr, !rv_ff || rsp_ready)
   `RAS_ASSERT_NEXT(a_load_prep, clock, reset, cmd.load, state_ff == ST_PREP)
endmodule
`default_nettype wire

// ----- sv/rect_add_rect_sum_fenwick_mod.sv -----
// Channel  Direction  Payload
// req      in         req_type event (update or query)
// rsp      out        rsp_type slot id and running answer
// csr      in         13-bit index_count
// From one accepted transaction to the next: an update runs three products, then reads and
// writes each tree node walked (up to 13); a query reads and accumulates each node walked
// (up to 12), then combines with the serial modular multiplier, which does every product.
// After reset a clearing pass zeroes the trees and answer table; no event is taken in it.
// A stalled rsp holds the engine in its final step; the next event waits for it.
`default_nettype none
module rect_add_rect_sum_fenwick_mod import ras_pkg::*; #(
   parameter int TREE_SIZE    = TREE_SIZE_DEF,
   parameter int ANSWER_SLOTS = ANSWER_SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [12:0] csr_data
);
   cmd_type    cmd;
   status_type status;
   logic [12:0] index_count_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) index_count_ff <= 13'd4096;
      else if (csr_valid) index_count_ff <= csr_data;
   end

   ras_ctrl u_ctrl (
      .clock(clock), .reset(reset), .status(status), .cmd(cmd),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready)
   );

   ras_datapath #(.TREE_SIZE(TREE_SIZE), .ANSWER_SLOTS(ANSWER_SLOTS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req(req_data), .index_count(index_count_ff), .rsp(rsp_data)
   );
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import ras_pkg::*;

   localparam longint unsigned P_MOD = 64'd1000000007;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 150;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [12:0] csr_data;

   rect_add_rect_sum_fenwick_mod u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // shadow copy of the engine state
   logic [29:0] sum_w[0:4096];
   logic [29:0] sum_wy[0:4096];
   logic [29:0] sum_wx[0:4096];
   logic [29:0] sum_wxy[0:4096];
   logic [29:0] answers[0:1023];
   int unsigned walk_bound;

   rsp_type answer_queue[$];
   int  mismatch_count;
   bit  failed;
   int  cycle_count;
   int  send_idle_pct;
   int  recv_idle_pct;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [29:0] add_p(input logic [29:0] a, input logic [29:0] b);
      return 30'(({34'd0, a} + {34'd0, b}) % P_MOD);
   endfunction

   function automatic logic [29:0] sub_p(input logic [29:0] a, input logic [29:0] b);
      return 30'(({34'd0, a} + P_MOD - {34'd0, b}) % P_MOD);
   endfunction

   function automatic logic [29:0] mul_p(input logic [29:0] a, input logic [29:0] b);
      return 30'(({34'd0, a} * {34'd0, b}) % P_MOD);
   endfunction

   // apply one accepted transaction; queries queue the expected answer
   task automatic predict_event(input req_type ev);
      logic [29:0] x, y, w, s0, s1, s2, s3, xp, yp, v;
      int unsigned i;
      longint unsigned mag;
      int slot;
      rsp_type r;
      x = 30'({33'd0, ev.x_coord} % P_MOD);
      y = 30'({33'd0, ev.y_coord} % P_MOD);
      if (ev.operation == 1'b0) begin
         if (ev.weight < 0) begin
            mag = 64'h1_0000_0000 - {32'd0, ev.weight};
            w = sub_p(30'd0, 30'(mag % P_MOD));
         end else begin
            w = 30'({32'd0, ev.weight} % P_MOD);
         end
         i = 32'(ev.y_index);
         if (i != 0) begin
            while (i <= walk_bound) begin
               sum_w[i]   = add_p(sum_w[i], w);
               sum_wy[i]  = add_p(sum_wy[i], mul_p(w, y));
               sum_wx[i]  = add_p(sum_wx[i], mul_p(w, x));
               sum_wxy[i] = add_p(sum_wxy[i], mul_p(mul_p(w, x), y));
               i = i + (i & (~i + 1));
            end
         end
      end else begin
         i = (32'(ev.y_index) > walk_bound) ? walk_bound : 32'(ev.y_index);
         s0 = '0; s1 = '0; s2 = '0; s3 = '0;
         while (i > 0) begin
            s0 = add_p(s0, sum_w[i]);
            s1 = add_p(s1, sum_wy[i]);
            s2 = add_p(s2, sum_wx[i]);
            s3 = add_p(s3, sum_wxy[i]);
            i = i - (i & (~i + 1));
         end
         xp = add_p(x, 30'd1);
         yp = add_p(y, 30'd1);
         v = mul_p(mul_p(xp, yp), s0);
         v = sub_p(v, mul_p(xp, s1));
         v = sub_p(v, mul_p(yp, s2));
         v = add_p(v, s3);
         slot = int'(ev.query_id);
         answers[slot] = ev.sign_negative ? sub_p(answers[slot], v) : add_p(answers[slot], v);
         r.answer_id = ev.query_id;
         r.answer_value = answers[slot];
         answer_queue = {answer_queue, r};
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (answer_queue.size() == 0) begin
            failed = 1'b1;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected answer: id %0d value %0d",
                        rsp_data.answer_id, rsp_data.answer_value);
         end else begin
            want = answer_queue.pop_front();
            if (rsp_data.answer_id !== want.answer_id ||
                rsp_data.answer_value !== want.answer_value) begin
               failed = 1'b1;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("answer mismatch: expected id %0d value %0d, got id %0d value %0d",
                           want.answer_id, want.answer_value,
                           rsp_data.answer_id, rsp_data.answer_value);
            end
         end
      end
   end

   // leaves req_valid high after acceptance; the next call or drain updates it
   task automatic send_event(input req_type ev);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (!req_ready);
      predict_event(ev);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (answer_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_index_count(input logic [12:0] value);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      walk_bound = (value > 13'd4096) ? 4096 : 32'(value);
   endtask

   function automatic req_type make_event(input bit op, input logic [30:0] x,
                                          input logic [30:0] y, input logic [12:0] idx,
                                          input logic [31:0] w, input logic [9:0] qid,
                                          input bit neg);
      req_type ev;
      ev.operation = op; ev.x_coord = x; ev.y_coord = y; ev.y_index = idx;
      ev.weight = w; ev.query_id = qid; ev.sign_negative = neg;
      return ev;
   endfunction

   function automatic req_type random_event();
      req_type ev;
      int pick;
      int top;
      top = (walk_bound == 0) ? 1 : int'(walk_bound);
      ev.operation = 1'($urandom_range(1));
      pick = int'($urandom_range(99));
      if (pick < 80)      ev.y_index = 13'($urandom_range(top, 1));
      else if (pick < 88) ev.y_index = 13'd0;
      else if (pick < 96) ev.y_index = 13'($urandom_range(8191));
      else                ev.y_index = $urandom_range(1) ? 13'd4096 : 13'd8191;
      ev.x_coord = ($urandom_range(3) == 0) ? 31'($urandom_range(1000)) : 31'($urandom());
      ev.y_coord = ($urandom_range(3) == 0) ? 31'($urandom_range(1000)) : 31'($urandom());
      ev.weight  = ($urandom_range(3) == 0) ? 32'($urandom_range(20)) - 32'd10 : $urandom();
      ev.query_id = ($urandom_range(1) == 0) ? 10'($urandom_range(7)) : 10'($urandom());
      ev.sign_negative = 1'($urandom_range(1));
      return ev;
   endfunction

   task automatic test_empty_after_reset();
      send_event(make_event(1, 31'h7fffffff, 31'h7fffffff, 13'd4096, 32'd0, 10'd0, 0));
      send_event(make_event(1, 31'd0, 31'd0, 13'd1, 32'd0, 10'd1023, 1));
   endtask

   task automatic test_field_extremes();
      send_event(make_event(0, 31'h7fffffff, 31'h7fffffff, 13'd1, 32'h7fffffff, 10'd0, 0));
      send_event(make_event(0, 31'd1000000006, 31'd1000000007, 13'd4096, 32'h80000000,
                            10'h3ff, 1));
      send_event(make_event(0, 31'd0, 31'd0, 13'd2, 32'hffffffff, 10'd5, 0));
      send_event(make_event(1, 31'd1000000006, 31'h7fffffff, 13'd4096, 32'd0, 10'd1023, 0));
      send_event(make_event(1, 31'h7fffffff, 31'd0, 13'd1, 32'hffffffff, 10'd0, 1));
      send_event(make_event(1, 31'd5, 31'd7, 13'd3, 32'd0, 10'd1023, 1));
   endtask

   task automatic test_index_edges();
      // index zero and beyond the bound on both operations
      send_event(make_event(0, 31'd3, 31'd4, 13'd0, 32'd99, 10'd0, 0));
      send_event(make_event(0, 31'd3, 31'd4, 13'd8191, 32'd99, 10'd0, 0));
      send_event(make_event(1, 31'd3, 31'd4, 13'd0, 32'd0, 10'd2, 0));
      send_event(make_event(1, 31'd3, 31'd4, 13'd8191, 32'd0, 10'd2, 0));
      write_index_count(13'd1);
      send_event(make_event(0, 31'd10, 31'd20, 13'd1, 32'd7, 10'd0, 0));
      send_event(make_event(0, 31'd10, 31'd20, 13'd2, 32'd7, 10'd0, 0));
      send_event(make_event(1, 31'd30, 31'd40, 13'd5, 32'd0, 10'd3, 0));
      write_index_count(13'd0);
      send_event(make_event(0, 31'd1, 31'd1, 13'd1, 32'd1, 10'd0, 0));
      send_event(make_event(1, 31'd9, 31'd9, 13'd1, 32'd0, 10'd3, 1));
      write_index_count(13'd8191);
      send_event(make_event(0, 31'd2, 31'd2, 13'd4096, 32'd11, 10'd0, 0));
      send_event(make_event(1, 31'd9, 31'd9, 13'd8191, 32'd0, 10'd4, 0));
   endtask

   task automatic test_random_traffic(input int s_pct, input int r_pct, input int items);
      int n;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (n = 0; n < items; n++) begin
         if (n % 150 == 0) begin
            case ($urandom_range(4))
               0: write_index_count(13'd1);
               1: write_index_count(13'd4096);
               2: write_index_count(13'd8191);
               3: write_index_count(13'($urandom_range(64, 2)));
               default: write_index_count(13'($urandom()));
            endcase
         end
         send_event(random_event());
      end
   endtask

   initial begin
      integer k;
      for (k = 0; k <= 4096; k++) begin
         sum_w[k] = '0; sum_wy[k] = '0; sum_wx[k] = '0; sum_wxy[k] = '0;
      end
      for (k = 0; k < 1024; k++) answers[k] = '0;
      walk_bound = 4096;
      mismatch_count = 0;
      failed = 1'b0;
      cycle_count = 0;
      send_idle_pct = 30;
      recv_idle_pct = 67;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_empty_after_reset();
      test_field_extremes();
      test_index_edges();
      test_random_traffic(30, 67, 610);
      test_random_traffic(67, 30, 610);
      test_random_traffic(0, 0, 610);
      drain();

      if (!failed && answer_queue.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire
